// ----- sv/lfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lfr_pkg;

  localparam int WORD_W  = 52;
  localparam int SEED_W  = 30;
  localparam int BLEN_W  = 16;
  localparam logic [BLEN_W-1:0] BATCH_LEN_RESET = 16'd1009;

  typedef enum logic {
    OP_SEED = 1'b0,
    OP_GEN  = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SEED_W-1:0] seed;
  } entry_t;

  // head of the request queue as seen by the back end
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_head_t;

endpackage
`default_nettype wire

// ----- sv/lfr_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface lfr_in_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [lfr_pkg::SEED_W-1:0] seed;
  modport source (output valid, func, seed, input ready);
  modport sink   (input valid, func, seed, output ready);
endinterface
`default_nettype wire

// ----- sv/lfr_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface lfr_out_if;
  logic                      valid;
  logic                      ready;
  logic [lfr_pkg::WORD_W-1:0] value;
  logic                      batch_end;
  modport source (output valid, value, batch_end, input ready);
  modport sink   (input valid, value, batch_end, output ready);
endinterface
`default_nettype wire

// ----- sv/lfr_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface lfr_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lfr_pkg::BLEN_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- sv/lfr_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- sv/lfr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lfr_front (
  input  wire logic          clk,
  input  wire logic          rst,
  lfr_in_if.sink             req,
  input  wire logic          pop,
  output lfr_pkg::queue_head_t q
);
  // two-entry queue, decodes func into an operation code
  lfr_pkg::entry_t slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign q.valid   = (count != 2'd0);
  assign q.entry   = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr].op   <= req.func ? lfr_pkg::OP_GEN : lfr_pkg::OP_SEED;
      slot[wptr].seed <= req.seed;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ----- sv/lfr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lfr_back #(
  parameter int LONG_LAG   = 100,
  parameter int SHORT_LAG  = 37,
  parameter int SEP_ROUNDS = 70
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire lfr_pkg::queue_head_t        q,
  output logic                             pop,
  input  wire logic [lfr_pkg::BLEN_W-1:0]  batch_len,
  lfr_out_if.source                        rsp
);
  localparam int W        = lfr_pkg::WORD_W;
  localparam int EL_W     = W + 1;
  localparam int LAG_W    = $clog2(LONG_LAG);
  localparam int WORK_LEN = 2 * LONG_LAG - 1;
  localparam int WORK_W   = $clog2(WORK_LEN);
  localparam int T_W      = $clog2(SEP_ROUNDS + 1);
  localparam int BW       = lfr_pkg::BLEN_W;

  localparam logic [WORK_W-1:0] J_LAST = WORK_W'(WORK_LEN - 1);
  localparam logic [WORK_W-1:0] J_LEN  = WORK_W'(WORK_LEN);
  localparam logic [WORK_W-1:0] J_L    = WORK_W'(LONG_LAG);
  localparam logic [WORK_W-1:0] J_S    = WORK_W'(SHORT_LAG);
  localparam logic [WORK_W-1:0] J_DIFF = WORK_W'(LONG_LAG - SHORT_LAG);
  localparam logic [WORK_W-1:0] J_BEND = WORK_W'(LONG_LAG - SHORT_LAG + 2);
  localparam logic [WORK_W-1:0] J_ONE  = WORK_W'(1);
  localparam logic [WORK_W-1:0] J_TWO  = WORK_W'(2);
  localparam logic [LAG_W-1:0]  H_LAST = LAG_W'(LONG_LAG - 1);
  localparam logic [LAG_W:0]    H_DIFF = (LAG_W+1)'(LONG_LAG - SHORT_LAG);
  localparam logic [LAG_W:0]    H_LEN  = (LAG_W+1)'(LONG_LAG);

  typedef enum logic [21:0] {
    S_IDLE   = 22'd1 << 0,
    S_GEN_RD = 22'd1 << 1,
    S_GEN_WR = 22'd1 << 2,
    S_INIT   = 22'd1 << 3,
    S_RCHK   = 22'd1 << 4,
    S_A_RD   = 22'd1 << 5,
    S_A_WR   = 22'd1 << 6,
    S_B_RD   = 22'd1 << 7,
    S_B_WR   = 22'd1 << 8,
    S_C_RD   = 22'd1 << 9,
    S_C_CHK  = 22'd1 << 10,
    S_C_WA   = 22'd1 << 11,
    S_C_RB   = 22'd1 << 12,
    S_C_WB   = 22'd1 << 13,
    S_D_CHK  = 22'd1 << 14,
    S_D_RD   = 22'd1 << 15,
    S_D_WR   = 22'd1 << 16,
    S_D_W0   = 22'd1 << 17,
    S_D_WS   = 22'd1 << 18,
    S_E      = 22'd1 << 19,
    S_LD_RD  = 22'd1 << 20,
    S_LD_WR  = 22'd1 << 21
  } state_t;

  state_t state, state_next;
  logic [WORK_W-1:0]  j, j_next;
  logic [W-1:0]       ss, ss_next;
  logic [lfr_pkg::SEED_W-1:0] s, s_next;
  logic [T_W-1:0]     t, t_next;
  logic [EL_W-1:0]    hv, hv_next;
  logic [LAG_W-1:0]   head, head_next;
  logic [BW-1:0]      pos, pos_next;
  logic [LONG_LAG-1:0] vld, vld_next;
  logic               va, va_next, vb, vb_next;
  logic               out_valid, out_valid_next;
  logic [W-1:0]       out_value, out_value_next;
  logic               out_end, out_end_next;

  logic               w_we;
  logic [WORK_W-1:0]  w_waddr, w_raddr;
  logic [EL_W-1:0]    w_wdata, w_rd;
  logic               r_we;
  logic [LAG_W-1:0]   r_waddr, r_raddr_a, r_raddr_b;
  logic [W-1:0]       r_wdata, r_rd_a, r_rd_b;
  logic [LAG_W:0]     psum;
  logic [LAG_W-1:0]   partner;
  logic [W-1:0]       gv, gp;
  logic [W:0]         dbl;
  logic               out_free;

  lfr_ram #(.WIDTH(EL_W), .DEPTH(WORK_LEN)) u_work (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rd)
  );
  // two copies of the ring give the head and partner reads in the same cycle
  lfr_ram #(.WIDTH(W), .DEPTH(LONG_LAG)) u_ring_a (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr_a), .rdata(r_rd_a)
  );
  lfr_ram #(.WIDTH(W), .DEPTH(LONG_LAG)) u_ring_b (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr_b), .rdata(r_rd_b)
  );

  assign rsp.valid     = out_valid;
  assign rsp.value     = out_value;
  assign rsp.batch_end = out_end;
  assign out_free      = !out_valid || rsp.ready;

  assign psum    = {1'b0, head} + H_DIFF;
  assign partner = (psum >= H_LEN) ? LAG_W'(psum - H_LEN) : psum[LAG_W-1:0];
  assign gv      = va ? r_rd_a : '0;
  assign gp      = vb ? r_rd_b : '0;
  assign dbl     = {ss, 1'b0};

  always_comb begin
    state_next     = state;
    j_next         = j;
    ss_next        = ss;
    s_next         = s;
    t_next         = t;
    hv_next        = hv;
    head_next      = head;
    pos_next       = pos;
    vld_next       = vld;
    va_next        = va;
    vb_next        = vb;
    out_valid_next = out_valid && !rsp.ready;
    out_value_next = out_value;
    out_end_next   = out_end;
    pop            = 1'b0;
    w_we           = 1'b0;
    w_waddr        = j;
    w_wdata        = w_rd;
    w_raddr        = j;
    r_we           = 1'b0;
    r_waddr        = head;
    r_wdata        = '0;
    r_raddr_a      = head;
    r_raddr_b      = partner;
    unique case (state)
      S_IDLE: begin
        if (q.valid) begin
          pop     = 1'b1;
          s_next  = q.entry.seed;
          t_next  = T_W'(SEP_ROUNDS - 1);
          j_next  = '0;
          ss_next = W'({({1'b0, q.entry.seed} + 31'd2), 1'b0});
          state_next = (q.entry.op == lfr_pkg::OP_GEN) ? S_GEN_RD : S_INIT;
        end
      end
      S_GEN_RD: begin
        va_next    = vld[head];
        vb_next    = vld[partner];
        state_next = S_GEN_WR;
      end
      S_GEN_WR: begin
        if (out_free) begin
          r_we           = 1'b1;
          r_wdata        = gv + gp;
          vld_next[head] = 1'b1;
          out_valid_next = 1'b1;
          out_value_next = gv;
          head_next      = (head == H_LAST) ? '0 : head + LAG_W'(1);
          if (({1'b0, pos} + 17'd1) >= {1'b0, batch_len}) begin
            out_end_next = 1'b1;
            pos_next     = '0;
          end else begin
            out_end_next = 1'b0;
            pos_next     = pos + BW'(1);
          end
          state_next = S_IDLE;
        end
      end
      S_INIT: begin
        w_we = 1'b1;
        if (j == J_ONE) begin
          w_wdata = {1'b1, ss | W'(1)};
        end else if (j < J_L) begin
          w_wdata = {1'b0, ss};
        end else begin
          w_wdata = '0;
        end
        if (j < J_L) begin
          ss_next = dbl[W] ? dbl[W-1:0] + W'(2) : dbl[W-1:0];
        end
        j_next = j + J_ONE;
        if (j == J_LAST) begin
          state_next = S_RCHK;
        end
      end
      S_RCHK: begin
        if (t == '0) begin
          j_next     = '0;
          state_next = S_LD_RD;
        end else begin
          j_next     = J_L - J_ONE;
          state_next = S_A_RD;
        end
      end
      S_A_RD: state_next = S_A_WR;
      S_A_WR: begin
        w_we    = 1'b1;
        w_waddr = j + j;
        if (j == J_ONE) begin
          j_next     = J_LAST;
          state_next = S_B_RD;
        end else begin
          j_next     = j - J_ONE;
          state_next = S_A_RD;
        end
      end
      S_B_RD: state_next = S_B_WR;
      S_B_WR: begin
        w_we    = 1'b1;
        w_waddr = J_LEN - j;
        w_wdata = {1'b0, w_rd[W-1:0] - W'(w_rd[W])};
        j_next  = j - J_TWO;
        if (j <= J_BEND) begin
          j_next     = J_LAST;
          state_next = S_C_RD;
        end else begin
          state_next = S_B_RD;
        end
      end
      S_C_RD: state_next = S_C_CHK;
      S_C_CHK: begin
        hv_next = w_rd;
        w_raddr = j - J_DIFF;
        if (w_rd[W]) begin
          state_next = S_C_WA;
        end else if (j == J_L) begin
          state_next = S_D_CHK;
        end else begin
          j_next     = j - J_ONE;
          state_next = S_C_RD;
        end
      end
      S_C_WA: begin
        w_we       = 1'b1;
        w_waddr    = j - J_DIFF;
        w_wdata    = {~w_rd[W], w_rd[W-1:0] + hv[W-1:0]};
        state_next = S_C_RB;
      end
      S_C_RB: begin
        w_raddr    = j - J_L;
        state_next = S_C_WB;
      end
      S_C_WB: begin
        w_we    = 1'b1;
        w_waddr = j - J_L;
        w_wdata = {~w_rd[W], w_rd[W-1:0] + hv[W-1:0]};
        if (j == J_L) begin
          state_next = S_D_CHK;
        end else begin
          j_next     = j - J_ONE;
          state_next = S_C_RD;
        end
      end
      S_D_CHK: begin
        j_next     = J_L;
        state_next = s[0] ? S_D_RD : S_E;
      end
      S_D_RD: begin
        w_raddr    = j - J_ONE;
        state_next = S_D_WR;
      end
      S_D_WR: begin
        w_we = 1'b1;
        if (j == J_L) begin
          hv_next = w_rd;
        end
        if (j == J_ONE) begin
          state_next = S_D_W0;
        end else begin
          j_next     = j - J_ONE;
          state_next = S_D_RD;
        end
      end
      S_D_W0: begin
        w_we       = 1'b1;
        w_waddr    = '0;
        w_wdata    = hv;
        w_raddr    = J_S;
        state_next = hv[W] ? S_D_WS : S_E;
      end
      S_D_WS: begin
        w_we       = 1'b1;
        w_waddr    = J_S;
        w_wdata    = {~w_rd[W], w_rd[W-1:0] + hv[W-1:0]};
        state_next = S_E;
      end
      S_E: begin
        if (s != '0) begin
          s_next = s >> 1;
        end else begin
          t_next = t - T_W'(1);
        end
        state_next = S_RCHK;
      end
      S_LD_RD: state_next = S_LD_WR;
      S_LD_WR: begin
        r_we    = 1'b1;
        r_waddr = (j < J_S) ? LAG_W'(j + J_DIFF) : LAG_W'(j - J_S);
        r_wdata = w_rd[W-1:0];
        vld_next = '1;
        if (j == J_L - J_ONE) begin
          head_next  = '0;
          pos_next   = '0;
          state_next = S_IDLE;
        end else begin
          j_next     = j + J_ONE;
          state_next = S_LD_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    j         <= j_next;
    ss        <= ss_next;
    s         <= s_next;
    t         <= t_next;
    hv        <= hv_next;
    va        <= va_next;
    vb        <= vb_next;
    out_value <= out_value_next;
    out_end   <= out_end_next;
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      pos       <= '0;
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      pos       <= pos_next;
      vld       <= vld_next;
      out_valid <= out_valid_next;
    end
  end
endmodule
`default_nettype wire

// ----- sv/lagged_fibonacci_rng_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// generate request: after acceptance the queue is popped, both ring copies are read,
//   then the sum is written back and the result register loaded once the output is free;
//   the back end takes the next request only once the last one is done
// seed request, default lags: rounds = seed bit length + 69, all run through the single
//   work memory
// reset: synchronous; ring reads as zero, head and batch count cleared, batch_len 1009
module lagged_fibonacci_rng_core #(
  parameter int LONG_LAG   = 100,
  parameter int SHORT_LAG  = 37,
  parameter int SEP_ROUNDS = 70
) (
  input  wire logic clk,
  input  wire logic rst,
  lfr_in_if.sink    req,
  lfr_cfg_if.sink   cfg,
  lfr_out_if.source rsp
);
  // batch length register, written any time the config channel is valid
  logic [lfr_pkg::BLEN_W-1:0] batch_len;
  lfr_pkg::queue_head_t       q;
  logic                       pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_len <= lfr_pkg::BATCH_LEN_RESET;
    end else if (cfg.valid) begin
      batch_len <= cfg.data;
    end
  end

  // front end: accepts and decodes requests into a short queue
  lfr_front u_front (
    .clk(clk), .rst(rst), .req(req), .pop(pop), .q(q)
  );

  // back end: ring update for generate, seeding sequencer for reseed
  lfr_back #(
    .LONG_LAG(LONG_LAG), .SHORT_LAG(SHORT_LAG), .SEP_ROUNDS(SEP_ROUNDS)
  ) u_back (
    .clk(clk), .rst(rst), .q(q), .pop(pop), .batch_len(batch_len), .rsp(rsp)
  );

  // the back end never drains an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q.valid) else $error("pop from empty queue");

  // an accepted request is visible at the queue head next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> q.valid) else $error("request lost in queue");
endmodule
`default_nettype wire

// ----- bench/lagged_fibonacci_rng_core_tb.sv -----
`timescale 1ns / 1ps
module lagged_fibonacci_rng_core_tb;

  localparam int LAG_L     = 100;
  localparam int LAG_S     = 37;
  localparam int SEP       = 70;
  localparam int WORK_N    = 2 * LAG_L - 1;
  localparam int MAX_WAIT  = 18;
  // a seed request can keep every channel quiet while the ring is seeded
  localparam int QUIET_MAX = 600000;
  localparam int DRAIN     = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lfr_in_if  req_ch ();
  lfr_cfg_if cfg_ch ();
  lfr_out_if rsp_ch ();

  lagged_fibonacci_rng_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .cfg (cfg_ch.sink),
    .rsp (rsp_ch.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // one value as it should leave the block
  typedef struct {
    logic [lfr_pkg::WORD_W-1:0] value;
    logic                       batch_end;
  } sample_t;

  // one row of the directed table
  typedef struct {
    lfr_pkg::op_t               op;
    logic [lfr_pkg::SEED_W-1:0] seed;
    bit                         typed;
    logic [lfr_pkg::WORD_W-1:0] value;
    logic                       batch_end;
  } row_t;

  // generator shadow state
  logic [lfr_pkg::WORD_W-1:0] ring [LAG_L];
  int unsigned       head;
  logic [15:0]       pos;
  logic [15:0]       blen;

  sample_t pending_samples[$];
  int      fail_count;
  int      quiet_cycles;
  bit      no_idle;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // polynomial-squaring seeding of the shadow ring
  task automatic seed_ring(input logic [lfr_pkg::SEED_W-1:0] seed);
    logic [lfr_pkg::WORD_W-1:0] work [WORK_N];
    bit                low  [WORK_N];
    logic [63:0]       ss;
    logic [63:0]       s;
    int                t;
    int                a;
    int                b;
    ss = (64'd2 * ({34'd0, seed} + 64'd2)) & ((64'd1 << lfr_pkg::WORD_W) - 1);
    s  = {34'd0, seed};
    t  = SEP - 1;
    for (int j = 0; j < LAG_L; j++) begin
      work[j] = ss[lfr_pkg::WORD_W-1:0];
      low[j]  = 1'b0;
      ss = ss + ss;
      if (ss >= (64'd1 << lfr_pkg::WORD_W)) ss = ss - (64'd1 << lfr_pkg::WORD_W) + 64'd2;
    end
    for (int j = LAG_L; j < WORK_N; j++) begin
      work[j] = '0;
      low[j]  = 1'b0;
    end
    work[1] = work[1] + 1'b1;
    low[1]  = 1'b1;
    while (t != 0) begin
      // square: spread words to even slots
      for (int j = LAG_L - 1; j > 0; j--) begin
        low[j + j]  = low[j];
        work[j + j] = work[j];
      end
      for (int j = WORK_N - 1; j > LAG_L - LAG_S; j -= 2) begin
        low[WORK_N - j]  = 1'b0;
        work[WORK_N - j] = work[j] - low[j];
      end
      // fold the high half back modulo the characteristic polynomial
      for (int j = WORK_N - 1; j >= LAG_L; j--) begin
        if (low[j]) begin
          a = j - (LAG_L - LAG_S);
          b = j - LAG_L;
          low[a]  ^= 1'b1;
          work[a] = work[a] + work[j];
          low[b]  ^= 1'b1;
          work[b] = work[b] + work[j];
        end
      end
      // multiply by z for a set seed bit
      if (s[0]) begin
        for (int j = LAG_L; j > 0; j--) begin
          low[j]  = low[j - 1];
          work[j] = work[j - 1];
        end
        low[0]  = low[LAG_L];
        work[0] = work[LAG_L];
        if (low[LAG_L]) begin
          low[LAG_S]  ^= 1'b1;
          work[LAG_S] = work[LAG_S] + work[LAG_L];
        end
      end
      if (s != 0) s = s >> 1;
      else t--;
    end
    for (int j = 0; j < LAG_S; j++) ring[j + LAG_L - LAG_S] = work[j];
    for (int j = LAG_S; j < LAG_L; j++) ring[j - LAG_S] = work[j];
    head = 0;
    pos  = '0;
  endtask

  // next value of the sequence and its end-of-batch mark
  function automatic sample_t next_sample();
    sample_t     r;
    int unsigned mate;
    mate = (head + LAG_L - LAG_S) % LAG_L;
    r.value = ring[head];
    ring[head] = ring[head] + ring[mate];
    head = (head + 1) % LAG_L;
    if ({1'b0, pos} + 17'd1 >= {1'b0, blen}) begin
      r.batch_end = 1'b1;
      pos = '0;
    end else begin
      r.batch_end = 1'b0;
      pos = pos + 1'b1;
    end
    return r;
  endfunction

  // drive one request, gap drawn per request; valid held high across back-to-back ones
  task automatic send(input lfr_pkg::op_t op, input logic [lfr_pkg::SEED_W-1:0] seed,
                      input bit typed, input sample_t typed_val);
    int      gap;
    sample_t r;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      @(negedge clk) req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.func  <= op;
    req_ch.seed  <= seed;
    do @(posedge clk); while (!req_ch.ready);
    if (op == lfr_pkg::OP_SEED) begin
      seed_ring(seed);
    end else begin
      r = next_sample();
      pending_samples.push_back(typed ? typed_val : r);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk) req_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // batch_len write, only with the block idle
  task automatic write_blen(input logic [15:0] len);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= len;
    do @(posedge clk); while (!cfg_ch.ready);
    blen = len;
    @(negedge clk) cfg_ch.valid <= 1'b0;
  endtask

  // response side: random stall before each value
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
      @(negedge clk);
    end
  end

  // compare each accepted value with the oldest expectation
  always @(posedge clk) begin
    sample_t e;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_samples.size() == 0) begin
        report("unexpected value", 64'(rsp_ch.value), 64'd0);
      end else begin
        e = pending_samples.pop_front();
        if (rsp_ch.value !== e.value) report("value", 64'(rsp_ch.value), 64'(e.value));
        if (rsp_ch.batch_end !== e.batch_end)
          report("batch_end", 64'(rsp_ch.batch_end), 64'(e.batch_end));
      end
    end
  end

  // watchdog on channel activity
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_MAX) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    row_t        dir_rows[$];
    row_t        rw;
    sample_t     tv;
    logic [15:0] phase_len [5];
    int          seeds_left;
    fail_count   = 0;
    quiet_cycles = 0;
    no_idle      = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.func  = lfr_pkg::OP_GEN;
    req_ch.seed  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    for (int i = 0; i < LAG_L; i++) ring[i] = '0;
    head = 0;
    pos  = '0;
    blen = lfr_pkg::BATCH_LEN_RESET;

    // values before any seed are zero; after that the shadow generator decides
    dir_rows = '{
      '{lfr_pkg::OP_GEN,  30'd0,          1'b1, 52'd0, 1'b0},
      '{lfr_pkg::OP_GEN,  30'd0,          1'b1, 52'd0, 1'b0},
      '{lfr_pkg::OP_GEN,  30'h3FFF_FFFF,  1'b1, 52'd0, 1'b0},
      '{lfr_pkg::OP_SEED, 30'd0,          1'b0, 52'd0, 1'b0},
      '{lfr_pkg::OP_GEN,  30'h3FFF_FFFF,  1'b0, 52'd0, 1'b0},
      '{lfr_pkg::OP_GEN,  30'd0,          1'b0, 52'd0, 1'b0},
      '{lfr_pkg::OP_GEN,  30'd0,          1'b0, 52'd0, 1'b0},
      '{lfr_pkg::OP_GEN,  30'd0,          1'b0, 52'd0, 1'b0},
      '{lfr_pkg::OP_SEED, 30'd1073741821, 1'b0, 52'd0, 1'b0},
      '{lfr_pkg::OP_GEN,  30'd0,          1'b0, 52'd0, 1'b0},
      '{lfr_pkg::OP_GEN,  30'd0,          1'b0, 52'd0, 1'b0},
      '{lfr_pkg::OP_GEN,  30'd0,          1'b0, 52'd0, 1'b0},
      '{lfr_pkg::OP_GEN,  30'd0,          1'b0, 52'd0, 1'b0},
      '{lfr_pkg::OP_GEN,  30'd0,          1'b0, 52'd0, 1'b0}
    };

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (dir_rows[i]) begin
      rw = dir_rows[i];
      tv.value     = rw.value;
      tv.batch_end = rw.batch_end;
      send(rw.op, rw.seed, rw.typed, tv);
    end
    wait_drained();

    // batch length extremes and 100, then a random legal one
    phase_len = '{16'd0, 16'd1, 16'hFFFF, 16'd100, 16'($urandom_range(100, 65535))};
    seeds_left = 2;
    foreach (phase_len[p]) begin
      write_blen(phase_len[p]);
      for (int n = 0; n < 200; n++) begin
        if (n % 50 == 0) no_idle = ($urandom_range(0, 2) == 0);
        // sender holds off until the block has delivered everything
        if (p == 0 && n == 100) wait_drained();
        // at most one seed per phase, never the last request of the phase
        if (seeds_left > 0 && (p == 1 || p == 3) && n == 60) begin
          send(lfr_pkg::OP_SEED, (p == 1) ? 30'($urandom_range(0, 1073741821))
                                          : 30'($urandom_range(0, 1023)), 1'b0, tv);
          seeds_left--;
        end else begin
          send(lfr_pkg::OP_GEN, 30'($urandom), 1'b0, tv);
        end
      end
      no_idle = 1'b0;
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
